@@ rtl/spi_mse_pkg.sv @@
// shared types and constants for the spi master shift engine
package spi_mse_pkg;

    localparam int MAX_WORD_BITS = 32;
    localparam int CFG_AW        = 5;
    localparam int CFG_DW        = 32;

    localparam logic [2:0] REG_HALF_PERIOD_DELAY = 3'd0;
    localparam logic [2:0] REG_WORD_BITS         = 3'd1;
    localparam logic [2:0] REG_LSB_FIRST         = 3'd2;
    localparam logic [2:0] REG_CLOCK_POLARITY    = 3'd3;
    localparam logic [2:0] REG_CLOCK_PHASE       = 3'd4;

    localparam logic [7:0] RST_HALF_PERIOD_DELAY = 8'd0;
    localparam logic [5:0] RST_WORD_BITS         = 6'd8;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_QUIET = 2'd1,
        PH_LEAD  = 2'd2,
        PH_TRAIL = 2'd3
    } t_phase;

    typedef struct packed {
        logic        start_req;
        logic [31:0] tx_word;
        logic        miso_level;
    } t_in;

    typedef struct packed {
        logic        sclk_level;
        logic        mosi_level;
        logic        busy_res;
        logic        done_res;
        logic [31:0] rx_word;
    } t_out;

    typedef struct packed {
        logic [7:0] half_period_delay;
        logic [5:0] word_bits;
        logic       lsb_first;
        logic       clock_polarity;
        logic       clock_phase;
    } t_cfg;

endpackage

@@ rtl/spi_mse_cfg.sv @@
// configuration register file behind the apb-style port
module spi_mse_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [spi_mse_pkg::CFG_AW-1:0]     paddr,
    input  logic [spi_mse_pkg::CFG_DW-1:0]     pwdata,
    output logic [spi_mse_pkg::CFG_DW-1:0]     prdata,
    output logic                               pready,
    output spi_mse_pkg::t_cfg                  o_cfg
);

    spi_mse_pkg::t_cfg r_cfg;
    logic [2:0]        w_idx;
    logic              w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_delay <= spi_mse_pkg::RST_HALF_PERIOD_DELAY;
            r_cfg.word_bits         <= spi_mse_pkg::RST_WORD_BITS;
            r_cfg.lsb_first         <= 1'b0;
            r_cfg.clock_polarity    <= 1'b0;
            r_cfg.clock_phase       <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                spi_mse_pkg::REG_HALF_PERIOD_DELAY: r_cfg.half_period_delay <= pwdata[7:0];
                spi_mse_pkg::REG_WORD_BITS:         r_cfg.word_bits         <= pwdata[5:0];
                spi_mse_pkg::REG_LSB_FIRST:         r_cfg.lsb_first         <= pwdata[0];
                spi_mse_pkg::REG_CLOCK_POLARITY:    r_cfg.clock_polarity    <= pwdata[0];
                spi_mse_pkg::REG_CLOCK_PHASE:       r_cfg.clock_phase       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            spi_mse_pkg::REG_HALF_PERIOD_DELAY: prdata = {24'd0, r_cfg.half_period_delay};
            spi_mse_pkg::REG_WORD_BITS:         prdata = {26'd0, r_cfg.word_bits};
            spi_mse_pkg::REG_LSB_FIRST:         prdata = {31'd0, r_cfg.lsb_first};
            spi_mse_pkg::REG_CLOCK_POLARITY:    prdata = {31'd0, r_cfg.clock_polarity};
            spi_mse_pkg::REG_CLOCK_PHASE:       prdata = {31'd0, r_cfg.clock_phase};
            default:                            prdata = '0;
        endcase
    end

endmodule

@@ rtl/spi_mse_core.sv @@
// spi shift state, phase sequencer and per-tick result logic
module spi_mse_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  spi_mse_pkg::t_cfg i_cfg,
    input  spi_mse_pkg::t_in  i_item,
    output spi_mse_pkg::t_out o_res
);

    spi_mse_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_tx, n_tx;
    logic [31:0] r_rx, n_rx;
    logic [5:0]  r_bit, n_bit;
    logic [7:0]  r_tick, n_tick;
    logic        r_sclk, n_sclk;
    logic        r_mosi, n_mosi;
    logic        w_done;
    logic [31:0] w_rx_out;
    logic [5:0]  w_n;
    logic        w_wait;
    logic [31:0] w_mask;
    logic [31:0] w_tx_load;

    function automatic logic [4:0] f_pos(input logic [5:0] j, input logic [5:0] n,
                                         input logic lsb);
        logic [5:0] p;
        p = lsb ? j : (n - 6'd1 - j);
        return p[4:0];
    endfunction

    function automatic logic f_tx_bit(input logic [31:0] data, input logic [5:0] j,
                                      input logic [5:0] n, input logic lsb);
        logic r;
        if (j >= n) r = 1'b1;
        else r = data[f_pos(j, n, lsb)];
        return r;
    endfunction

    always_comb begin
        w_n = i_cfg.word_bits;
        if (w_n == 6'd0) w_n = 6'd1;
        if (w_n > 6'(spi_mse_pkg::MAX_WORD_BITS)) w_n = 6'(spi_mse_pkg::MAX_WORD_BITS);
    end

    assign w_mask    = 32'hFFFF_FFFF >> (6'd32 - w_n);
    assign w_tx_load = i_item.tx_word & w_mask;
    assign w_wait    = (r_phase != spi_mse_pkg::PH_IDLE) && (r_tick < i_cfg.half_period_delay);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (r_phase == spi_mse_pkg::PH_IDLE) begin
            if (i_item.start_req) n_phase = spi_mse_pkg::PH_QUIET;
        end else if (!w_wait) begin
            case (r_phase)
                spi_mse_pkg::PH_QUIET: begin
                    n_phase = (r_bit == 6'd0) ? spi_mse_pkg::PH_LEAD : spi_mse_pkg::PH_IDLE;
                end
                spi_mse_pkg::PH_LEAD:  n_phase = spi_mse_pkg::PH_TRAIL;
                spi_mse_pkg::PH_TRAIL: begin
                    n_phase = (r_bit < w_n) ? spi_mse_pkg::PH_LEAD : spi_mse_pkg::PH_QUIET;
                end
                default: n_phase = spi_mse_pkg::PH_IDLE;
            endcase
        end
    end

    // shift datapath and pin levels
    always_comb begin
        n_tx     = r_tx;
        n_rx     = r_rx;
        n_bit    = r_bit;
        n_tick   = r_tick;
        n_sclk   = r_sclk;
        n_mosi   = r_mosi;
        w_done   = 1'b0;
        w_rx_out = '0;
        if (r_phase == spi_mse_pkg::PH_IDLE) begin
            if (i_item.start_req) begin
                n_tx   = w_tx_load;
                n_rx   = '0;
                n_bit  = '0;
                n_tick = '0;
                n_sclk = i_cfg.clock_polarity;
                if (!i_cfg.clock_phase) n_mosi = f_tx_bit(w_tx_load, 6'd0, w_n, i_cfg.lsb_first);
            end
        end else if (w_wait) begin
            n_tick = r_tick + 8'd1;
        end else begin
            n_tick = '0;
            case (r_phase)
                spi_mse_pkg::PH_LEAD: begin
                    n_sclk = i_cfg.clock_polarity;
                    if (!i_cfg.clock_phase) begin
                        n_mosi = f_tx_bit(r_tx, r_bit + 6'd1, w_n, i_cfg.lsb_first);
                    end else if (r_bit < w_n && i_item.miso_level) begin
                        n_rx = r_rx | (32'd1 << f_pos(r_bit, w_n, i_cfg.lsb_first));
                    end
                    n_bit = r_bit + 6'd1;
                end
                default: begin
                    if ((r_phase == spi_mse_pkg::PH_QUIET && r_bit == 6'd0) ||
                        (r_phase == spi_mse_pkg::PH_TRAIL && r_bit < w_n)) begin
                        // leading edge
                        n_sclk = ~i_cfg.clock_polarity;
                        if (i_cfg.clock_phase) begin
                            n_mosi = f_tx_bit(r_tx, r_bit, w_n, i_cfg.lsb_first);
                        end else if (r_bit < w_n && i_item.miso_level) begin
                            n_rx = r_rx | (32'd1 << f_pos(r_bit, w_n, i_cfg.lsb_first));
                        end
                    end else begin
                        n_sclk = i_cfg.clock_polarity;
                        n_mosi = 1'b1;
                        if (r_phase == spi_mse_pkg::PH_QUIET) begin
                            w_done   = 1'b1;
                            w_rx_out = r_rx;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= spi_mse_pkg::PH_IDLE;
            r_tx    <= '0;
            r_rx    <= '0;
            r_bit   <= '0;
            r_tick  <= '0;
            r_sclk  <= 1'b0;
            r_mosi  <= 1'b1;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_tx    <= n_tx;
            r_rx    <= n_rx;
            r_bit   <= n_bit;
            r_tick  <= n_tick;
            r_sclk  <= n_sclk;
            r_mosi  <= n_mosi;
        end
    end

    assign o_res.sclk_level = n_sclk;
    assign o_res.mosi_level = n_mosi;
    assign o_res.busy_res   = (n_phase != spi_mse_pkg::PH_IDLE);
    assign o_res.done_res   = w_done;
    assign o_res.rx_word    = w_rx_out;

endmodule

@@ rtl/spi_master_shift_engine_unit.sv @@
// top level of the spi master shift engine: input register, core, result register
//
// channel | direction | handshake             | payload
// in      | input     | i_in_valid/o_in_stall  | i_in_data  (t_in)
// out     | output    | o_out_valid/i_out_stall| o_out_data (t_out)
// cfg     | input     | apb psel/penable       | paddr, pwdata, prdata
//
// one tick per transfer, one transfer accepted every cycle while the result is not stalled
// each transfer passes two registers: input register, then result register
// the tick logic in spi_mse_core sits between those two registers
// synchronous active-low reset returns the engine to idle with mosi high
// a stalled result holds the core; the input register takes one more transfer
module spi_master_shift_engine_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  spi_mse_pkg::t_in               i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output spi_mse_pkg::t_out              o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spi_mse_pkg::CFG_AW-1:0] paddr,
    input  logic [spi_mse_pkg::CFG_DW-1:0] pwdata,
    output logic [spi_mse_pkg::CFG_DW-1:0] prdata,
    output logic                           pready
);

    spi_mse_pkg::t_cfg w_cfg;
    spi_mse_pkg::t_in  r_in_data;
    spi_mse_pkg::t_out w_res;
    spi_mse_pkg::t_out r_out_data;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              w_in_acc;
    logic              w_adv;

    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    spi_mse_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    spi_mse_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_cfg   (w_cfg),
        .i_item  (r_in_data),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ rtl/spi_mse_checker.sv @@
// port-level checker for the spi master shift engine, bound to the top level
module spi_mse_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input spi_mse_pkg::t_out o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // input side only backs up behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // completion ends the transfer
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res)
        else $error("done while busy");

    // received word only shown on completion
    a_rx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.done_res |-> o_out_data.rx_word == 32'd0)
        else $error("rx word nonzero without done");

    // mosi rests high outside a transfer
    a_mosi_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.busy_res |-> o_out_data.mosi_level)
        else $error("mosi low while idle");

endmodule

bind spi_master_shift_engine_unit spi_mse_checker u_spi_mse_checker (.*);

@@ bench/testbench.sv @@
// self-checking testbench for the spi master shift engine: per-tick pin prediction and compare
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_TICKS   = 450;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    spi_mse_pkg::t_in                    i_in_data = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    spi_mse_pkg::t_out                   o_out_data;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [spi_mse_pkg::CFG_AW-1:0]      paddr = '0;
    logic [spi_mse_pkg::CFG_DW-1:0]      pwdata = '0;
    logic [spi_mse_pkg::CFG_DW-1:0]      prdata;
    logic                                pready;

    spi_master_shift_engine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predicted configuration and engine state
    logic [7:0]           cfg_delay;
    logic [5:0]           cfg_bits;
    logic                 cfg_lsb;
    logic                 cfg_cpol;
    logic                 cfg_cpha;
    logic [31:0]          eng_tx;
    logic [31:0]          eng_rx;
    logic [5:0]           eng_count;
    spi_mse_pkg::t_phase  eng_phase;
    logic [7:0]           eng_ticks;
    logic                 eng_sclk;
    logic                 eng_mosi;

    spi_mse_pkg::t_out pending_pins[$];
    spi_mse_pkg::t_out want;

    int pin_errors    = 0;
    int ticks_sent    = 0;
    int words_seen    = 0;
    int config_phases = 0;
    int idle_cycles   = 0;
    int gap_pct       = 0;
    int stall_pct     = 0;
    int stall_left    = 0;

    function automatic void clear_engine_model();
        cfg_delay = spi_mse_pkg::RST_HALF_PERIOD_DELAY;
        cfg_bits  = spi_mse_pkg::RST_WORD_BITS;
        cfg_lsb   = 1'b0;
        cfg_cpol  = 1'b0;
        cfg_cpha  = 1'b0;
        eng_tx    = '0;
        eng_rx    = '0;
        eng_count = '0;
        eng_phase = spi_mse_pkg::PH_IDLE;
        eng_ticks = '0;
        eng_sclk  = 1'b0;
        eng_mosi  = 1'b1;
    endfunction

    function automatic int word_len();
        int n;
        n = int'(cfg_bits);
        if (n == 0) n = 1;
        if (n > spi_mse_pkg::MAX_WORD_BITS) n = spi_mse_pkg::MAX_WORD_BITS;
        return n;
    endfunction

    // position of bit j of the transfer within the word, -1 when outside it
    function automatic int wire_index(int j, int n);
        if (j >= n) return -1;
        return cfg_lsb ? j : n - 1 - j;
    endfunction

    function automatic logic tx_level(int j, int n);
        int p;
        p = wire_index(j, n);
        if (p < 0) return 1'b1;
        return eng_tx[p];
    endfunction

    function automatic void capture(int j, int n, logic miso);
        int p;
        p = wire_index(j, n);
        if (p >= 0 && miso) eng_rx[p] = 1'b1;
    endfunction

    function automatic void enter_lead(int n, logic miso);
        eng_phase = spi_mse_pkg::PH_LEAD;
        eng_sclk  = ~cfg_cpol;
        if (!cfg_cpha) capture(int'(eng_count), n, miso);
        else eng_mosi = tx_level(int'(eng_count), n);
    endfunction

    function automatic spi_mse_pkg::t_out advance_engine(spi_mse_pkg::t_in item);
        spi_mse_pkg::t_out res;
        int                n;
        logic [31:0]       mask;
        n = word_len();
        res = '0;
        if (eng_phase == spi_mse_pkg::PH_IDLE) begin
            if (item.start_req) begin
                mask      = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
                eng_tx    = item.tx_word & mask;
                eng_rx    = '0;
                eng_count = '0;
                eng_ticks = '0;
                eng_phase = spi_mse_pkg::PH_QUIET;
                eng_sclk  = cfg_cpol;
                if (!cfg_cpha) eng_mosi = tx_level(0, n);
            end
        end else if (eng_ticks < cfg_delay) begin
            eng_ticks = eng_ticks + 8'd1;
        end else begin
            eng_ticks = '0;
            case (eng_phase)
                spi_mse_pkg::PH_QUIET: begin
                    if (eng_count == 6'd0) begin
                        enter_lead(n, item.miso_level);
                    end else begin
                        eng_phase    = spi_mse_pkg::PH_IDLE;
                        res.done_res = 1'b1;
                        res.rx_word  = eng_rx;
                        eng_mosi     = 1'b1;
                        eng_sclk     = cfg_cpol;
                    end
                end
                spi_mse_pkg::PH_LEAD: begin
                    eng_phase = spi_mse_pkg::PH_TRAIL;
                    eng_sclk  = cfg_cpol;
                    if (!cfg_cpha) eng_mosi = tx_level(int'(eng_count) + 1, n);
                    else capture(int'(eng_count), n, item.miso_level);
                    eng_count = eng_count + 6'd1;
                end
                default: begin
                    if (int'(eng_count) < n) begin
                        enter_lead(n, item.miso_level);
                    end else begin
                        eng_phase = spi_mse_pkg::PH_QUIET;
                        eng_sclk  = cfg_cpol;
                        eng_mosi  = 1'b1;
                    end
                end
            endcase
        end
        res.sclk_level = eng_sclk;
        res.mosi_level = eng_mosi;
        res.busy_res   = (eng_phase != spi_mse_pkg::PH_IDLE);
        return res;
    endfunction

    // one tick transfer, entered and left just after a falling edge
    task automatic push_tick(spi_mse_pkg::t_in item);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        pending_pins.push_back(advance_engine(item));
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic tick(logic start, logic [31:0] tx, logic miso);
        spi_mse_pkg::t_in item;
        item.start_req  = start;
        item.tx_word    = tx;
        item.miso_level = miso;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        push_tick(item);
    endtask

    task automatic idle_ticks(int count);
        repeat (count) tick(1'b0, $urandom, 1'($urandom_range(0, 1)));
    endtask

    // one spi word; noise_pct sets how often start is raised again while busy
    task automatic shift_word(logic [31:0] tx, int noise_pct);
        tick(1'b1, tx, 1'($urandom_range(0, 1)));
        while (eng_phase != spi_mse_pkg::PH_IDLE) begin
            tick($urandom_range(0, 99) < noise_pct, $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            spi_mse_pkg::REG_HALF_PERIOD_DELAY: cfg_delay = value[7:0];
            spi_mse_pkg::REG_WORD_BITS:         cfg_bits  = value[5:0];
            spi_mse_pkg::REG_LSB_FIRST:         cfg_lsb   = value[0];
            spi_mse_pkg::REG_CLOCK_POLARITY:    cfg_cpol  = value[0];
            spi_mse_pkg::REG_CLOCK_PHASE:       cfg_cpha  = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_config(spi_mse_pkg::t_cfg c);
        i_in_valid <= 1'b0;
        while (pending_pins.size() != 0) @(negedge i_clk);
        write_reg(spi_mse_pkg::REG_HALF_PERIOD_DELAY, 32'(c.half_period_delay));
        write_reg(spi_mse_pkg::REG_WORD_BITS, 32'(c.word_bits));
        write_reg(spi_mse_pkg::REG_LSB_FIRST, 32'(c.lsb_first));
        write_reg(spi_mse_pkg::REG_CLOCK_POLARITY, 32'(c.clock_polarity));
        write_reg(spi_mse_pkg::REG_CLOCK_PHASE, 32'(c.clock_phase));
        config_phases++;
    endtask

    function automatic spi_mse_pkg::t_cfg random_setup();
        spi_mse_pkg::t_cfg c;
        int                r;
        r = $urandom_range(0, 99);
        c.half_period_delay = (r < 60) ? 8'd0 : (r < 90) ? 8'($urandom_range(1, 3))
                                                          : 8'($urandom_range(4, 20));
        r = $urandom_range(0, 99);
        if (r < 65)      c.word_bits = 6'($urandom_range(1, 8));
        else if (r < 90) c.word_bits = 6'($urandom_range(9, 32));
        else if (r < 95) c.word_bits = 6'd0;
        else             c.word_bits = 6'($urandom_range(33, 63));
        // keep long phases on short words
        if (c.half_period_delay > 3 && (c.word_bits > 8 || c.word_bits == 0))
            c.word_bits = 6'($urandom_range(1, 8));
        c.lsb_first      = 1'($urandom_range(0, 1));
        c.clock_polarity = 1'($urandom_range(0, 1));
        c.clock_phase    = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic logic [31:0] random_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'hFFFF_FFFF;
        if (r == 1) return 32'h0000_0000;
        return $urandom;
    endfunction

    function automatic int pick_pct();
        int r;
        r = $urandom_range(0, 3);
        return (r < 2) ? 0 : (r == 2) ? 10 : 30;
    endfunction

    task automatic test_reset_state();
        idle_ticks(3);
        shift_word(32'h0000_00A5, 0);
        idle_ticks(2);
    endtask

    task automatic test_spi_modes();
        spi_mse_pkg::t_cfg c;
        for (int m = 0; m < 4; m++) begin
            c.half_period_delay = 8'd0;
            c.word_bits         = (m % 2) ? 6'd1 : 6'd32;
            c.lsb_first         = (m == 1 || m == 2);
            c.clock_polarity    = m[1];
            c.clock_phase       = m[0];
            apply_config(c);
            shift_word((m == 0) ? 32'hFFFF_FFFF : (m == 1) ? 32'h0 : $urandom, 0);
            shift_word($urandom, 0);
        end
    endtask

    task automatic test_word_limits();
        spi_mse_pkg::t_cfg c;
        c = '{half_period_delay: 8'd1, word_bits: 6'd0, lsb_first: 1'b1,
              clock_polarity: 1'b0, clock_phase: 1'b1};
        apply_config(c);
        shift_word(32'hFFFF_FFFE, 0);
        c = '{half_period_delay: 8'd0, word_bits: 6'd63, lsb_first: 1'b0,
              clock_polarity: 1'b1, clock_phase: 1'b0};
        apply_config(c);
        shift_word($urandom, 0);
        c.word_bits = 6'd33;
        c.lsb_first = 1'b1;
        apply_config(c);
        shift_word($urandom, 0);
    endtask

    task automatic test_start_while_busy();
        spi_mse_pkg::t_cfg c;
        c = '{half_period_delay: 8'd0, word_bits: 6'd4, lsb_first: 1'b0,
              clock_polarity: 1'b0, clock_phase: 1'b0};
        apply_config(c);
        shift_word($urandom, 100);
        shift_word($urandom, 100);
    endtask

    task automatic test_long_phase();
        spi_mse_pkg::t_cfg c;
        c = '{half_period_delay: 8'd60, word_bits: 6'd1, lsb_first: 1'b1,
              clock_polarity: 1'b1, clock_phase: 1'b1};
        apply_config(c);
        shift_word(32'h0000_0001, 5);
    endtask

    task automatic test_random_traffic();
        int first;
        first = ticks_sent;
        while (ticks_sent - first < RANDOM_TICKS) begin
            gap_pct   = pick_pct();
            stall_pct = pick_pct();
            apply_config(random_setup());
            repeat ($urandom_range(1, 4)) begin
                idle_ticks($urandom_range(0, 3));
                shift_word(random_word(), ($urandom_range(0, 3) == 0) ? 50 : 10);
            end
        end
    endtask

    task automatic test_steady_tail();
        gap_pct   = 0;
        stall_pct = 0;
        repeat (2) begin
            apply_config(random_setup());
            repeat (3) shift_word(random_word(), 20);
        end
    endtask

    // receiver stall in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(1, 13) - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pins.size() == 0) begin
                if (pin_errors < 10)
                    $display("%0t: result transfer with nothing expected: %p", $time, o_out_data);
                pin_errors++;
            end else begin
                want = pending_pins.pop_front();
                if (o_out_data.sclk_level !== want.sclk_level ||
                    o_out_data.mosi_level !== want.mosi_level ||
                    o_out_data.busy_res   !== want.busy_res   ||
                    o_out_data.done_res   !== want.done_res   ||
                    o_out_data.rx_word    !== want.rx_word) begin
                    if (pin_errors < 10)
                        $display({"%0t: mismatch sclk/mosi/busy/done/rx",
                                  " want %b %b %b %b %h got %b %b %b %b %h"},
                                 $time, want.sclk_level, want.mosi_level, want.busy_res,
                                 want.done_res, want.rx_word, o_out_data.sclk_level,
                                 o_out_data.mosi_level, o_out_data.busy_res,
                                 o_out_data.done_res, o_out_data.rx_word);
                    pin_errors++;
                end
                if (want.done_res) words_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        clear_engine_model();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_state();
        test_spi_modes();
        test_word_limits();
        test_start_while_busy();
        test_long_phase();
        test_random_traffic();
        test_steady_tail();
        i_in_valid <= 1'b0;
        while (pending_pins.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("summary: %0d ticks sent, %0d spi words received, %0d register setups",
                 ticks_sent, words_seen, config_phases);
        $display("summary: all four spi modes, both bit orders, lengths 0 to 63, delays 0 to 60");
        if (pin_errors == 0 && pending_pins.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d mismatches", pin_errors);
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/spi_mse_pkg.sv
rtl/spi_mse_cfg.sv
rtl/spi_mse_core.sv
rtl/spi_master_shift_engine_unit.sv
rtl/spi_mse_checker.sv
bench/testbench.sv
